>>> src/euler_xyz_to_rotation_matrix_assert.svh
// Assertion macros used by the Euler angle to rotation matrix RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define EX2R_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ex2r assertion failed");

// A condition that must hold in the cycle after the antecedent.
`define EX2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ex2r assertion failed");

`endif

>>> src/ex2r_pkg.sv
// Shared types and constants for the Euler angle to rotation matrix block.
// No dependencies.
`default_nettype none

package ex2r_pkg;

  // CORDIC datapath width: 30 fraction bits and room for +-8 rad.
  localparam int CW = 34;
  // Width of a finished sine or cosine.
  localparam int SCW = 32;
  localparam int FRAC = 30;
  localparam int TABLE_LEN = 30;

  localparam logic signed [CW-1:0] PI_Q = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q = 34'sd652032874;

  // One angle in flight through the CORDIC chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } lane_t;

  // The three angles of one item travel together.
  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } lanes_t;

  // Arctangent of 2^-i with 30 fraction bits, truncated.
  function automatic logic signed [CW-1:0] atan_q(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      default: r = 34'sd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/ex2r_cordic_cell.sv
// One CORDIC rotation stage, applied to the roll, pitch and yaw lanes at once.
// Depends on ex2r_pkg for the lane types and the arctangent table.
`default_nettype none

module ex2r_cordic_cell
  import ex2r_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire lanes_t lanes_in,
  output logic        valid,
  output lanes_t      lanes
);

  localparam logic signed [CW-1:0] ATAN = atan_q(STAGE);

  // Rotate one lane toward zero residual angle.
  function automatic lane_t rotate(input lane_t l);
    lane_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = l.y >>> STAGE;
    dy = l.x >>> STAGE;
    r = l;
    if (!l.z[CW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - ATAN;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + ATAN;
    end
    return r;
  endfunction

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (en) begin
      lanes.roll  <= rotate(lanes_in.roll);
      lanes.pitch <= rotate(lanes_in.pitch);
      lanes.yaw   <= rotate(lanes_in.yaw);
    end
  end

endmodule

`default_nettype wire

>>> src/ex2r_matrix.sv
// Products, sums, rounding and saturation that build the nine matrix elements.
// Depends on ex2r_pkg for the sine and cosine width.
`default_nettype none

module ex2r_matrix
  import ex2r_pkg::*;
#(
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         ready,
  input  wire logic signed [SCW-1:0]   sr,
  input  wire logic signed [SCW-1:0]   cr,
  input  wire logic signed [SCW-1:0]   st,
  input  wire logic signed [SCW-1:0]   ct,
  input  wire logic signed [SCW-1:0]   sy,
  input  wire logic signed [SCW-1:0]   cy,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [ELEMENT_BITS-1:0] r11,
  output logic signed [ELEMENT_BITS-1:0] r12,
  output logic signed [ELEMENT_BITS-1:0] r13,
  output logic signed [ELEMENT_BITS-1:0] r21,
  output logic signed [ELEMENT_BITS-1:0] r22,
  output logic signed [ELEMENT_BITS-1:0] r23,
  output logic signed [ELEMENT_BITS-1:0] r31,
  output logic signed [ELEMENT_BITS-1:0] r32,
  output logic signed [ELEMENT_BITS-1:0] r33
);

  localparam int SH = 62 - ELEMENT_BITS;
  localparam logic signed [65:0] LIM = 66'sd1 <<< (ELEMENT_BITS - 2);
  localparam logic signed [65:0] HALF = 66'sd1 <<< (SH - 1);
  localparam logic signed [63:0] HALF30 = 64'sd1 <<< (FRAC - 1);

  // Round half up to the element format and clamp to +-1.0.
  function automatic logic signed [ELEMENT_BITS-1:0] elem(input logic signed [64:0] v);
    logic signed [65:0] t;
    t = ($signed({v[64], v}) + HALF) >>> SH;
    if (t > LIM) begin
      t = LIM;
    end else if (t < -LIM) begin
      t = -LIM;
    end
    return t[ELEMENT_BITS-1:0];
  endfunction

  // Round a double-precision product back to 30 fraction bits.
  function automatic logic signed [SCW-1:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + HALF30) >>> FRAC;
    return t[SCW-1:0];
  endfunction

  logic v1;
  logic v2;
  logic en1;
  logic en2;
  logic en3;

  // Stall chain: a stage moves when it is empty or the next one moves.
  assign en3   = !out_valid || !out_stall;
  assign en2   = !v2 || en3;
  assign en1   = !v1 || en2;
  assign ready = en1;

  // First stage: the two-factor products.
  logic signed [63:0] p_ctcy, p_ctsy, p_ctsr, p_ctcr, p_srst, p_crst;
  logic signed [63:0] p_crsy, p_crcy, p_srsy, p_srcy;
  logic signed [SCW-1:0] st1, sy1, cy1;

  always_ff @(posedge clk) begin
    if (en1) begin
      p_ctcy <= ct * cy;
      p_ctsy <= ct * sy;
      p_ctsr <= ct * sr;
      p_ctcr <= ct * cr;
      p_srst <= sr * st;
      p_crst <= cr * st;
      p_crsy <= cr * sy;
      p_crcy <= cr * cy;
      p_srsy <= sr * sy;
      p_srcy <= sr * cy;
      st1    <= st;
      sy1    <= sy;
      cy1    <= cy;
    end
  end

  // Second stage: triple products from the rounded inner products.
  logic signed [SCW-1:0] srst;
  logic signed [SCW-1:0] crst;
  logic signed [63:0] q_a, q_b, q_c, q_d;
  logic signed [63:0] q_ctcy, q_ctsy, q_ctsr, q_ctcr, q_crsy, q_crcy, q_srsy, q_srcy;
  logic signed [SCW-1:0] st2;

  assign srst = rnd30(p_srst);
  assign crst = rnd30(p_crst);

  always_ff @(posedge clk) begin
    if (en2) begin
      q_a    <= srst * cy1;
      q_b    <= srst * sy1;
      q_c    <= crst * cy1;
      q_d    <= crst * sy1;
      q_ctcy <= p_ctcy;
      q_ctsy <= p_ctsy;
      q_ctsr <= p_ctsr;
      q_ctcr <= p_ctcr;
      q_crsy <= p_crsy;
      q_crcy <= p_crcy;
      q_srsy <= p_srsy;
      q_srcy <= p_srcy;
      st2    <= st1;
    end
  end

  // Third stage: sums, then rounding and saturation into the output register.
  logic signed [64:0] s13;
  assign s13 = -($signed({{33{st2[SCW-1]}}, st2}) <<< FRAC);

  always_ff @(posedge clk) begin
    if (en3) begin
      r11 <= elem($signed({q_ctcy[63], q_ctcy}));
      r12 <= elem($signed({q_ctsy[63], q_ctsy}));
      r13 <= elem(s13);
      r21 <= elem($signed({q_a[63], q_a}) - $signed({q_crsy[63], q_crsy}));
      r22 <= elem($signed({q_b[63], q_b}) + $signed({q_crcy[63], q_crcy}));
      r23 <= elem($signed({q_ctsr[63], q_ctsr}));
      r31 <= elem($signed({q_c[63], q_c}) + $signed({q_srsy[63], q_srsy}));
      r32 <= elem($signed({q_d[63], q_d}) - $signed({q_srcy[63], q_srcy}));
      r33 <= elem($signed({q_ctcr[63], q_ctcr}));
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/euler_xyz_to_rotation_matrix.sv
// Euler angles (XYZ sequence) to rotation matrix. One item enters per cycle while in_stall
// is low. The transfer edge folds the angles into [-pi/2, pi/2], a row of CORDIC_STAGES
// cells (at most 30 are used) turns out sine and cosine of all three angles, and three
// stages of multipliers and adders build and round the nine elements.
// Every stage holds its item while the next is full, so empty slots close up under a
// stall on the result side and the input keeps flowing until the whole row is full.
// Depends on ex2r_pkg, ex2r_cordic_cell, ex2r_matrix and the assertion macro header.
`default_nettype none

`include "euler_xyz_to_rotation_matrix_assert.svh"

module euler_xyz_to_rotation_matrix
  import ex2r_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int ELEMENT_BITS = 16,
  parameter int CORDIC_STAGES = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ANGLE_BITS-1:0]  roll,
  input  wire logic signed [ANGLE_BITS-1:0]  pitch,
  input  wire logic signed [ANGLE_BITS-1:0]  yaw,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ELEMENT_BITS-1:0]     r11,
  output logic signed [ELEMENT_BITS-1:0]     r12,
  output logic signed [ELEMENT_BITS-1:0]     r13,
  output logic signed [ELEMENT_BITS-1:0]     r21,
  output logic signed [ELEMENT_BITS-1:0]     r22,
  output logic signed [ELEMENT_BITS-1:0]     r23,
  output logic signed [ELEMENT_BITS-1:0]     r31,
  output logic signed [ELEMENT_BITS-1:0]     r32,
  output logic signed [ELEMENT_BITS-1:0]     r33
);

  localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int WSH = 33 - ANGLE_BITS;

  // Widen an angle to 30 fraction bits and fold it into [-pi/2, pi/2].
  function automatic lane_t fold(input logic signed [ANGLE_BITS-1:0] a);
    lane_t l;
    logic signed [CW-1:0] w;
    w = $signed({{(CW-ANGLE_BITS){a[ANGLE_BITS-1]}}, a}) <<< WSH;
    l.x = GAIN_Q;
    l.y = '0;
    l.neg = 1'b0;
    l.z = w;
    if (w > HALF_PI_Q) begin
      l.z = w - PI_Q;
      l.neg = 1'b1;
    end else if (w < -HALF_PI_Q) begin
      l.z = w + PI_Q;
      l.neg = 1'b1;
    end
    return l;
  endfunction

  // Undo the fold on a finished sine or cosine.
  function automatic logic signed [SCW-1:0] fix(input logic signed [CW-1:0] v,
                                                input logic neg);
    logic signed [CW-1:0] t;
    t = neg ? -v : v;
    return t[SCW-1:0];
  endfunction

  wire logic [N:0]   v;
  logic   [N+1:0]    go;
  wire lanes_t       cl [N+1];
  logic              mat_ready;
  logic              fold_valid;
  lanes_t            fold_lanes;

  // Register k moves when it is empty or register k+1 moves.
  assign go[N+1] = mat_ready;
  for (genvar k = 0; k <= N; k++) begin : g_go
    assign go[k] = !v[k] || go[k+1];
  end
  assign in_stall = !go[0];

  // Fold stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (go[0]) begin
      fold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      fold_lanes.roll  <= fold(roll);
      fold_lanes.pitch <= fold(pitch);
      fold_lanes.yaw   <= fold(yaw);
    end
  end

  assign v[0]  = fold_valid;
  assign cl[0] = fold_lanes;

  // Row of CORDIC cells.
  for (genvar k = 0; k < N; k++) begin : g_cell
    ex2r_cordic_cell #(
      .STAGE(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (go[k+1]),
      .in_valid(v[k]),
      .lanes_in(cl[k]),
      .valid   (v[k+1]),
      .lanes   (cl[k+1])
    );
  end

  // Matrix products and output register.
  ex2r_matrix #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v[N]),
    .ready    (mat_ready),
    .sr       (fix(cl[N].roll.y, cl[N].roll.neg)),
    .cr       (fix(cl[N].roll.x, cl[N].roll.neg)),
    .st       (fix(cl[N].pitch.y, cl[N].pitch.neg)),
    .ct       (fix(cl[N].pitch.x, cl[N].pitch.neg)),
    .sy       (fix(cl[N].yaw.y, cl[N].yaw.neg)),
    .cy       (fix(cl[N].yaw.x, cl[N].yaw.neg)),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .r11      (r11),
    .r12      (r12),
    .r13      (r13),
    .r21      (r21),
    .r22      (r22),
    .r23      (r23),
    .r31      (r31),
    .r32      (r32),
    .r33      (r33)
  );

  localparam logic signed [ELEMENT_BITS-1:0] ONE = ELEMENT_BITS'(1) <<< (ELEMENT_BITS - 2);

  // The input is held back only when the fold stage is occupied and cannot move.
  `EX2R_ASSERT_ALWAYS(a_stall_full, !in_stall || (v[0] && !go[1]))
  // An item held in the fold stage stays there.
  `EX2R_ASSERT_NEXT(a_fold_hold, v[0] && !go[1], v[0])
  // Saturation keeps the elements within +-1.0.
  `EX2R_ASSERT_ALWAYS(a_r13_range, !out_valid || (r13 <= ONE && r13 >= -ONE))
  `EX2R_ASSERT_ALWAYS(a_r22_range, !out_valid || (r22 <= ONE && r22 >= -ONE))

endmodule

`default_nettype wire
